FILE: rtl/tfq_pkg.sv
// Shared types and codes for the three-level feedback queue scheduler.
// Used by the controller, datapath, top level and checker; depends on nothing.
package tfq_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SLICE = 2'd1;
  localparam logic [1:0] OP_KILL  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [3:0] OC_IDLE       = 4'd0;
  localparam logic [3:0] OC_FINISHED   = 4'd1;
  localparam logic [3:0] OC_TO_LEVEL2  = 4'd2;
  localparam logic [3:0] OC_TO_LEVEL3  = 4'd3;
  localparam logic [3:0] OC_IO_REQUEUE = 4'd4;
  localparam logic [3:0] OC_REQUEUE_L3 = 4'd5;
  localparam logic [3:0] OC_SWAP       = 4'd6;
  localparam logic [3:0] OC_ADDED      = 4'd7;
  localparam logic [3:0] OC_REJECTED   = 4'd8;
  localparam logic [3:0] OC_KILLED     = 4'd9;
  localparam logic [3:0] OC_KILL_MISS  = 4'd10;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  localparam logic [1:0] BOOST_NONE = 2'd0;
  localparam logic [1:0] BOOST_L2   = 2'd1;
  localparam logic [1:0] BOOST_L3   = 2'd2;

  localparam logic [2:0] CFG_QUANTUM1 = 3'd0;
  localparam logic [2:0] CFG_QUANTUM2 = 3'd1;
  localparam logic [2:0] CFG_QUANTUM3 = 3'd2;
  localparam logic [2:0] CFG_LIMIT2   = 3'd3;
  localparam logic [2:0] CFG_LIMIT3   = 3'd4;

  localparam logic [7:0]  QUANTUM1_RST = 8'd8;
  localparam logic [7:0]  QUANTUM2_RST = 8'd16;
  localparam logic [7:0]  QUANTUM3_RST = 8'd24;
  localparam logic [15:0] LIMIT2_RST   = 16'd35;
  localparam logic [15:0] LIMIT3_RST   = 16'd40;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] len;
    logic        io;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef enum logic [1:0] {WSRC_IN, WSRC_RD, WSRC_NEW, WSRC_JOB} wsrc_t;
  typedef enum logic [1:0] {ROFF_HEAD, ROFF_K, ROFF_K1} roff_t;
  typedef enum logic {RID_IN, RID_RD} rid_t;

  typedef struct packed {
    logic        latch_in;
    logic [1:0]  rd_lvl;
    roff_t       rd_off;
    logic        wr_en;
    logic [1:0]  wr_lvl;
    logic        wr_tail;
    wsrc_t       wr_src;
    logic        pop_en;
    logic [1:0]  pop_lvl;
    logic        dec1;
    logic        k_clr;
    logic        k_inc;
    logic        clr_age2;
    logic        clr_age3;
    logic        run_en;
    logic [1:0]  run_lvl;
    logic        boost_ld;
    logic [1:0]  boost;
    logic        res_ld;
    rid_t        res_id;
    logic [1:0]  res_lvl;
    logic [3:0]  res_oc;
    logic        load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] room;
    logic [2:0] nonempty;
    logic       age2_over;
    logic       age3_over;
    logic       k_end;
    logic       k1_end;
    logic       id_match;
    logic       left_zero;
    logic       rd_io;
  } sts_t;

endpackage

FILE: rtl/three_level_feedback_queue_scheduler.sv
// Three-level feedback queue scheduler, top level.
// Instantiates tfq_ctrl and tfq_datapath; uses tfq_pkg.
//
// One item at a time: an item is taken only while the controller is idle, and
// its result is held in an output register, so a new item may be accepted while
// the previous result still waits. An add passes through S_ADD to the result
// state S_FIN and a no-op goes straight there; a kill scans level 1 (S_KRD,
// S_KCMP) and then shifts the entries behind the match down (S_KSRD, S_KSWR); a
// slice runs S_BOOST, the promotion loop (S_PRD, S_PWR), S_PICK and, unless all
// levels are empty, S_RUN, then S_SWRD, S_SWWR and S_SWJOB when a demotion needs
// a swap. A result waits in S_FIN while an earlier result is stalled. The level
// RAMs (one read and one write per cycle, registered read) pace promotion and
// the kill search and shift: each entry takes a read state and then a write or
// compare state. Each level holds at most QUEUE_DEPTH-1 jobs. Queue storage is
// not cleared at reset; the pointers are, so no stale entry is ever read.
module three_level_feedback_queue_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_proc_id,
  input  logic [15:0] in_job_length,
  input  logic        in_io_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_served_id,
  output logic [7:0]  out_ran_ticks,
  output logic [1:0]  out_level,
  output logic [3:0]  out_outcome,
  output logic [1:0]  out_boosted,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  tfq_pkg::cmd_t cmd;
  tfq_pkg::sts_t sts;

  // Sequence each operation; hold the result until the consumer takes it.
  tfq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Queues, ages, config and result registers.
  tfq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_proc_id    (in_proc_id),
    .in_job_length (in_job_length),
    .in_io_request (in_io_request),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_served_id (out_served_id),
    .out_ran_ticks (out_ran_ticks),
    .out_level     (out_level),
    .out_outcome   (out_outcome),
    .out_boosted   (out_boosted)
  );

endmodule

FILE: rtl/tfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tfq_datapath.sv
// Datapath: three level RAMs, pointers, ages, config registers and result registers.
// Depends on tfq_pkg and tfq_ram; driven by tfq_ctrl commands.
module tfq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      in_proc_id,
  input  logic [15:0]      in_job_length,
  input  logic             in_io_request,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  tfq_pkg::cmd_t    cmd,
  output tfq_pkg::sts_t    sts,
  output logic [15:0]      out_served_id,
  output logic [7:0]       out_ran_ticks,
  output logic [1:0]       out_level,
  output logic [3:0]       out_outcome,
  output logic [1:0]       out_boosted
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW:0]   QD_W = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] CAP  = AW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= QD_W) s = s - QD_W;
    return s[AW-1:0];
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  logic [AW-1:0] head_r [3];
  logic [AW-1:0] cnt_r  [3];
  logic [AW-1:0] head_nxt [3];
  logic [AW-1:0] cnt_nxt  [3];
  logic [AW-1:0] k_r;
  logic [1:0]    rsel_r;
  logic [15:0]   age2_r, age3_r;
  logic [7:0]    q1_r, q2_r, q3_r;
  logic [15:0]   lim2_r, lim3_r;
  tfq_pkg::job_t in_job_r, job_r;
  logic [15:0]   res_id_r;
  logic [7:0]    res_ran_r;
  logic [1:0]    res_lvl_r, res_oc_pad;
  logic [3:0]    res_oc_r;
  logic [1:0]    res_boost_r;
  logic [15:0]   out_id_r;
  logic [7:0]    out_ran_r;
  logic [1:0]    out_lvl_r, out_boost_r;
  logic [3:0]    out_oc_r;

  logic [tfq_pkg::JOB_W-1:0] ram_rdata [3];
  logic [AW-1:0]             ram_waddr [3];
  logic [AW-1:0]             ram_raddr [3];
  logic [2:0]                ram_we;
  logic [tfq_pkg::JOB_W-1:0] wdata;
  logic [AW-1:0]             roff;
  tfq_pkg::job_t             rd_job, job_new;
  logic [7:0]                quantum, run;

  assign res_oc_pad = 2'd0;

  always_comb begin
    case (rsel_r)
      tfq_pkg::LVL_1: rd_job = tfq_pkg::job_t'(ram_rdata[0]);
      tfq_pkg::LVL_2: rd_job = tfq_pkg::job_t'(ram_rdata[1]);
      default:        rd_job = tfq_pkg::job_t'(ram_rdata[2]);
    endcase
  end

  always_comb begin
    case (cmd.run_lvl)
      tfq_pkg::LVL_1: quantum = q1_r;
      tfq_pkg::LVL_2: quantum = q2_r;
      default:        quantum = q3_r;
    endcase
    run = (rd_job.len < {8'd0, quantum}) ? rd_job.len[7:0] : quantum;
    job_new.id  = rd_job.id;
    job_new.len = rd_job.len - {8'd0, run};
    job_new.io  = rd_job.io;
  end

  always_comb begin
    case (cmd.wr_src)
      tfq_pkg::WSRC_IN:  wdata = in_job_r;
      tfq_pkg::WSRC_RD:  wdata = rd_job;
      tfq_pkg::WSRC_NEW: wdata = job_new;
      default:           wdata = job_r;
    endcase
    case (cmd.rd_off)
      tfq_pkg::ROFF_HEAD: roff = '0;
      tfq_pkg::ROFF_K:    roff = k_r;
      default:            roff = k_r + AW'(1);
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_level
    assign ram_we[i]    = cmd.wr_en && (cmd.wr_lvl == 2'(i + 1));
    assign ram_waddr[i] = cmd.wr_tail ? slot(head_r[i], cnt_r[i]) : slot(head_r[i], k_r);
    assign ram_raddr[i] = slot(head_r[i], roff);

    tfq_ram #(.WIDTH(tfq_pkg::JOB_W), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we[i]),
      .waddr (ram_waddr[i]),
      .wdata (wdata),
      .raddr (ram_raddr[i]),
      .rdata (ram_rdata[i])
    );

    always_comb begin
      logic inc, dec;
      inc = cmd.wr_en && cmd.wr_tail && (cmd.wr_lvl == 2'(i + 1));
      dec = (cmd.pop_en && (cmd.pop_lvl == 2'(i + 1))) || ((i == 0) && cmd.dec1);
      cnt_nxt[i]  = cnt_r[i] + AW'(inc) - AW'(dec);
      head_nxt[i] = (cmd.pop_en && (cmd.pop_lvl == 2'(i + 1))) ?
                    slot(head_r[i], AW'(1)) : head_r[i];
    end

    assign sts.room[i]     = (cnt_r[i] != CAP);
    assign sts.nonempty[i] = (cnt_r[i] != '0);
  end

  assign sts.age2_over = age2_r > lim2_r;
  assign sts.age3_over = age3_r > lim3_r;
  assign sts.k_end     = (k_r == cnt_r[0]);
  assign sts.k1_end    = ({1'b0, k_r} + (AW+1)'(1)) >= {1'b0, cnt_r[0]};
  assign sts.id_match  = (rd_job.id == in_job_r.id);
  assign sts.left_zero = (job_new.len == 16'd0);
  assign sts.rd_io     = rd_job.io;

  // Control state: pointers, ages, config.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      k_r    <= '0;
      age2_r <= '0;
      age3_r <= '0;
      q1_r   <= tfq_pkg::QUANTUM1_RST;
      q2_r   <= tfq_pkg::QUANTUM2_RST;
      q3_r   <= tfq_pkg::QUANTUM3_RST;
      lim2_r <= tfq_pkg::LIMIT2_RST;
      lim3_r <= tfq_pkg::LIMIT3_RST;
    end else begin
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
      if (cmd.k_clr) k_r <= '0;
      else if (cmd.k_inc) k_r <= k_r + AW'(1);
      if (cmd.run_en) begin
        unique case (cmd.run_lvl)
          tfq_pkg::LVL_1: begin
            age2_r <= sat_add(age2_r, run);
            age3_r <= sat_add(age3_r, run);
          end
          tfq_pkg::LVL_2: begin
            age2_r <= '0;
            age3_r <= sat_add(age3_r, run);
          end
          default: begin
            age2_r <= sat_add(age2_r, run);
            age3_r <= '0;
          end
        endcase
      end else begin
        if (cmd.clr_age2) age2_r <= '0;
        if (cmd.clr_age3) age3_r <= '0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tfq_pkg::CFG_QUANTUM1: q1_r   <= cfg_wdata[7:0];
          tfq_pkg::CFG_QUANTUM2: q2_r   <= cfg_wdata[7:0];
          tfq_pkg::CFG_QUANTUM3: q3_r   <= cfg_wdata[7:0];
          tfq_pkg::CFG_LIMIT2:   lim2_r <= cfg_wdata;
          tfq_pkg::CFG_LIMIT3:   lim3_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rsel_r <= cmd.rd_lvl;
    if (cmd.latch_in) begin
      in_job_r    <= {in_proc_id, in_job_length, in_io_request};
      res_id_r    <= '0;
      res_ran_r   <= '0;
      res_lvl_r   <= tfq_pkg::LVL_NONE;
      res_oc_r    <= tfq_pkg::OC_IDLE;
      res_boost_r <= tfq_pkg::BOOST_NONE;
    end else begin
      if (cmd.boost_ld) res_boost_r <= cmd.boost;
      if (cmd.run_en) begin
        job_r     <= job_new;
        res_ran_r <= run;
      end
      if (cmd.res_ld) begin
        res_id_r  <= (cmd.res_id == tfq_pkg::RID_IN) ? in_job_r.id : rd_job.id;
        res_lvl_r <= cmd.res_lvl | res_oc_pad;
        res_oc_r  <= cmd.res_oc;
      end
    end
    if (cmd.load_out) begin
      out_id_r    <= res_id_r;
      out_ran_r   <= res_ran_r;
      out_lvl_r   <= res_lvl_r;
      out_oc_r    <= res_oc_r;
      out_boost_r <= res_boost_r;
    end
  end

  assign out_served_id = out_id_r;
  assign out_ran_ticks = out_ran_r;
  assign out_level     = out_lvl_r;
  assign out_outcome   = out_oc_r;
  assign out_boosted   = out_boost_r;

endmodule

FILE: rtl/tfq_ctrl.sv
// Controller state machine: sequences add, kill search/shift, promotion and slice.
// Depends on tfq_pkg; issues commands to tfq_datapath and reads its status.
module tfq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_operation,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tfq_pkg::sts_t sts,
  output tfq_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_KRD, S_KCMP, S_KSRD, S_KSWR, S_BOOST, S_PRD, S_PWR,
    S_PICK, S_RUN, S_SWRD, S_SWWR, S_SWJOB, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [1:0] psrc_r, psrc_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    psrc_nxt  = psrc_r;
    cmd.wr_tail = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_operation)
            tfq_pkg::OP_ADD:   state_nxt = S_ADD;
            tfq_pkg::OP_SLICE: state_nxt = S_BOOST;
            tfq_pkg::OP_KILL: begin
              cmd.k_clr = 1'b1;
              state_nxt = S_KRD;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_ADD: begin
        cmd.res_ld = 1'b1;
        cmd.res_id = tfq_pkg::RID_IN;
        cmd.wr_src = tfq_pkg::WSRC_IN;
        cmd.res_oc = tfq_pkg::OC_ADDED;
        cmd.wr_en  = 1'b1;
        if (sts.room[0]) cmd.wr_lvl = tfq_pkg::LVL_1;
        else if (sts.room[1]) cmd.wr_lvl = tfq_pkg::LVL_2;
        else if (sts.room[2]) cmd.wr_lvl = tfq_pkg::LVL_3;
        else begin
          cmd.wr_en  = 1'b0;
          cmd.wr_lvl = tfq_pkg::LVL_NONE;
          cmd.res_oc = tfq_pkg::OC_REJECTED;
        end
        cmd.res_lvl = cmd.wr_lvl;
        state_nxt = S_FIN;
      end
      S_KRD: begin
        if (sts.k_end) begin
          cmd.res_ld  = 1'b1;
          cmd.res_id  = tfq_pkg::RID_IN;
          cmd.res_lvl = tfq_pkg::LVL_NONE;
          cmd.res_oc  = tfq_pkg::OC_KILL_MISS;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_lvl = tfq_pkg::LVL_1;
          cmd.rd_off = tfq_pkg::ROFF_K;
          state_nxt  = S_KCMP;
        end
      end
      S_KCMP: begin
        if (sts.id_match) state_nxt = S_KSRD;
        else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_KRD;
        end
      end
      S_KSRD: begin
        if (sts.k1_end) begin
          cmd.dec1    = 1'b1;
          cmd.res_ld  = 1'b1;
          cmd.res_id  = tfq_pkg::RID_IN;
          cmd.res_lvl = tfq_pkg::LVL_1;
          cmd.res_oc  = tfq_pkg::OC_KILLED;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_lvl = tfq_pkg::LVL_1;
          cmd.rd_off = tfq_pkg::ROFF_K1;
          state_nxt  = S_KSWR;
        end
      end
      S_KSWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_lvl  = tfq_pkg::LVL_1;
        cmd.wr_tail = 1'b0;
        cmd.wr_src  = tfq_pkg::WSRC_RD;
        cmd.k_inc   = 1'b1;
        state_nxt   = S_KSRD;
      end
      S_BOOST: begin
        if (sts.room[0] && sts.age2_over && sts.nonempty[1]) begin
          cmd.boost_ld = 1'b1;
          cmd.boost    = tfq_pkg::BOOST_L2;
          psrc_nxt     = tfq_pkg::LVL_2;
          state_nxt    = S_PRD;
        end else if (sts.room[0] && sts.age3_over && sts.nonempty[2]) begin
          cmd.boost_ld = 1'b1;
          cmd.boost    = tfq_pkg::BOOST_L3;
          psrc_nxt     = tfq_pkg::LVL_3;
          state_nxt    = S_PRD;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_PRD: begin
        if (sts.room[0] && sts.nonempty[psrc_r - 2'd1]) begin
          cmd.rd_lvl = psrc_r;
          cmd.rd_off = tfq_pkg::ROFF_HEAD;
          state_nxt  = S_PWR;
        end else begin
          cmd.clr_age2 = (psrc_r == tfq_pkg::LVL_2);
          cmd.clr_age3 = (psrc_r == tfq_pkg::LVL_3);
          state_nxt    = S_PICK;
        end
      end
      S_PWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_lvl  = tfq_pkg::LVL_1;
        cmd.wr_src  = tfq_pkg::WSRC_RD;
        cmd.pop_en  = 1'b1;
        cmd.pop_lvl = psrc_r;
        state_nxt   = S_PRD;
      end
      S_PICK: begin
        if (sts.nonempty[0]) lvl_nxt = tfq_pkg::LVL_1;
        else if (sts.nonempty[1]) lvl_nxt = tfq_pkg::LVL_2;
        else lvl_nxt = tfq_pkg::LVL_3;
        if (sts.nonempty != 3'b000) begin
          cmd.rd_lvl  = lvl_nxt;
          cmd.rd_off  = tfq_pkg::ROFF_HEAD;
          cmd.pop_en  = 1'b1;
          cmd.pop_lvl = lvl_nxt;
          state_nxt   = S_RUN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RUN: begin
        cmd.run_en  = 1'b1;
        cmd.run_lvl = lvl_r;
        cmd.res_ld  = 1'b1;
        cmd.res_id  = tfq_pkg::RID_RD;
        cmd.res_lvl = lvl_r;
        cmd.wr_src  = tfq_pkg::WSRC_NEW;
        state_nxt   = S_FIN;
        if (sts.left_zero) begin
          cmd.res_oc = tfq_pkg::OC_FINISHED;
        end else if (lvl_r == tfq_pkg::LVL_3) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_lvl = tfq_pkg::LVL_3;
          cmd.res_oc = tfq_pkg::OC_REQUEUE_L3;
        end else if (sts.rd_io) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_lvl = tfq_pkg::LVL_1;
          cmd.res_oc = tfq_pkg::OC_IO_REQUEUE;
        end else if ((lvl_r == tfq_pkg::LVL_1) && sts.room[1]) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_lvl = tfq_pkg::LVL_2;
          cmd.res_oc = tfq_pkg::OC_TO_LEVEL2;
        end else if (sts.room[2]) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_lvl = tfq_pkg::LVL_3;
          cmd.res_oc = tfq_pkg::OC_TO_LEVEL3;
        end else begin
          // Lower level full (both lower levels, from level 1): pull the next level's head up, then push job down.
          cmd.res_oc = tfq_pkg::OC_SWAP;
          state_nxt  = S_SWRD;
        end
      end
      S_SWRD: begin
        cmd.rd_lvl = lvl_r + 2'd1;
        cmd.rd_off = tfq_pkg::ROFF_HEAD;
        state_nxt  = S_SWWR;
      end
      S_SWWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_lvl  = lvl_r;
        cmd.wr_src  = tfq_pkg::WSRC_RD;
        cmd.pop_en  = 1'b1;
        cmd.pop_lvl = lvl_r + 2'd1;
        state_nxt   = S_SWJOB;
      end
      S_SWJOB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_lvl = lvl_r + 2'd1;
        cmd.wr_src = tfq_pkg::WSRC_JOB;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= tfq_pkg::LVL_NONE;
      psrc_r      <= tfq_pkg::LVL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      psrc_r      <= psrc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/tfq_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on tfq_pkg.
module tfq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_served_id,
  input logic [7:0]  out_ran_ticks,
  input logic [1:0]  out_level,
  input logic [3:0]  out_outcome,
  input logic [1:0]  out_boosted
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_outcome) && $stable(out_served_id))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == tfq_pkg::OC_IDLE) |->
      (out_served_id == 16'd0) && (out_ran_ticks == 8'd0) && (out_level == 2'd0))
    else $error("idle result carries data");

  a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == tfq_pkg::OC_ADDED) |->
      (out_level != tfq_pkg::LVL_NONE) && (out_ran_ticks == 8'd0) &&
      (out_boosted == tfq_pkg::BOOST_NONE))
    else $error("bad add result");

  a_miss_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_outcome == tfq_pkg::OC_REJECTED) ||
                  (out_outcome == tfq_pkg::OC_KILL_MISS)) |->
      (out_level == tfq_pkg::LVL_NONE))
    else $error("miss result names a level");

endmodule

bind three_level_feedback_queue_scheduler tfq_checker u_tfq_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench for the three-level feedback queue scheduler.
// Holds a behavioral model of the three job levels; depends on tfq_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LEVEL_CAP = DEPTH - 1;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  ticks;
    logic [1:0]  lvl;
    logic [3:0]  oc;
    logic [1:0]  boost;
  } sched_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_operation = tfq_pkg::OP_NOP;
  logic [15:0] in_proc_id = 0;
  logic [15:0] in_job_length = 0;
  logic in_io_request = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_served_id;
  logic [7:0] out_ran_ticks;
  logic [1:0] out_level;
  logic [3:0] out_outcome;
  logic [1:0] out_boosted;
  logic cfg_we = 0;
  logic [2:0] cfg_index = tfq_pkg::CFG_QUANTUM1;
  logic [15:0] cfg_wdata = 0;

  three_level_feedback_queue_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Model state: one queue per level, index 1..3 used.
  tfq_pkg::job_t lvl_q[1:3][$];
  int unsigned age2, age3;
  logic [7:0] quantum[1:3];
  logic [15:0] limit2, limit3;
  sched_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int stall_max = 0;  // receiver stall draws 0..stall_max
  bit use_ids_small = 1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  function automatic void model_reset();
    for (int l = 1; l <= 3; l++) lvl_q[l].delete();
    age2 = 0;
    age3 = 0;
    quantum[1] = tfq_pkg::QUANTUM1_RST;
    quantum[2] = tfq_pkg::QUANTUM2_RST;
    quantum[3] = tfq_pkg::QUANTUM3_RST;
    limit2 = tfq_pkg::LIMIT2_RST;
    limit3 = tfq_pkg::LIMIT3_RST;
  endfunction

  // Append a job at the tail of level l.
  function automatic void lvl_append(int l, tfq_pkg::job_t j);
    lvl_q[l].insert(lvl_q[l].size(), j);
  endfunction

  // Take the head job of level l.
  function automatic tfq_pkg::job_t lvl_take(int l);
    tfq_pkg::job_t j;
    j = lvl_q[l][0];
    lvl_q[l].delete(0);
    return j;
  endfunction

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    return (a + b > 65535) ? 65535 : a + b;
  endfunction

  // Promote level src into level 1 when its age is over the limit.
  function automatic bit try_promote(int src, ref int unsigned age, input int unsigned lim);
    if (!(lvl_q[1].size() < LEVEL_CAP && age > lim && lvl_q[src].size() > 0)) return 0;
    while (lvl_q[1].size() < LEVEL_CAP && lvl_q[src].size() > 0)
      lvl_append(1, lvl_take(src));
    age = 0;
    return 1;
  endfunction

  function automatic sched_result_t predict_slice();
    sched_result_t r;
    tfq_pkg::job_t j;
    int l;
    int unsigned run;
    r = '0;
    if (try_promote(2, age2, limit2)) r.boost = tfq_pkg::BOOST_L2;
    else if (try_promote(3, age3, limit3)) r.boost = tfq_pkg::BOOST_L3;
    l = 0;
    for (int k = 3; k >= 1; k--) if (lvl_q[k].size() > 0) l = k;
    if (l == 0) begin
      r.oc = tfq_pkg::OC_IDLE;
      return r;
    end
    j = lvl_take(l);
    run = (j.len < quantum[l]) ? j.len : quantum[l];
    j.len = j.len - run;
    if (l == 1) begin
      age2 = sat_add(age2, run);
      age3 = sat_add(age3, run);
    end else if (l == 2) begin
      age3 = sat_add(age3, run);
      age2 = 0;
    end else begin
      age2 = sat_add(age2, run);
      age3 = 0;
    end
    if (j.len == 0) r.oc = tfq_pkg::OC_FINISHED;
    else if (l == 3) begin
      lvl_append(3, j);
      r.oc = tfq_pkg::OC_REQUEUE_L3;
    end else if (j.io) begin
      lvl_append(1, j);
      r.oc = tfq_pkg::OC_IO_REQUEUE;
    end else if (l == 1) begin
      if (lvl_q[2].size() < LEVEL_CAP) begin
        lvl_append(2, j);
        r.oc = tfq_pkg::OC_TO_LEVEL2;
      end else if (lvl_q[3].size() < LEVEL_CAP) begin
        lvl_append(3, j);
        r.oc = tfq_pkg::OC_TO_LEVEL3;
      end else begin
        lvl_append(1, lvl_take(2));
        lvl_append(2, j);
        r.oc = tfq_pkg::OC_SWAP;
      end
    end else begin
      if (lvl_q[3].size() < LEVEL_CAP) begin
        lvl_append(3, j);
        r.oc = tfq_pkg::OC_TO_LEVEL3;
      end else begin
        lvl_append(2, lvl_take(3));
        lvl_append(3, j);
        r.oc = tfq_pkg::OC_SWAP;
      end
    end
    r.id = j.id;
    r.ticks = run[7:0];
    r.lvl = l[1:0];
    return r;
  endfunction

  function automatic sched_result_t predict_item(logic [1:0] op, logic [15:0] id,
                                                 logic [15:0] len, logic io);
    sched_result_t r;
    tfq_pkg::job_t j;
    r = '0;
    if (op == tfq_pkg::OP_ADD) begin
      j = '{id: id, len: len, io: io};
      r.id = id;
      r.oc = tfq_pkg::OC_ADDED;
      if (lvl_q[1].size() < LEVEL_CAP) begin
        lvl_append(1, j);
        r.lvl = tfq_pkg::LVL_1;
      end else if (lvl_q[2].size() < LEVEL_CAP) begin
        lvl_append(2, j);
        r.lvl = tfq_pkg::LVL_2;
      end else if (lvl_q[3].size() < LEVEL_CAP) begin
        lvl_append(3, j);
        r.lvl = tfq_pkg::LVL_3;
      end else begin
        r.oc = tfq_pkg::OC_REJECTED;
      end
    end else if (op == tfq_pkg::OP_SLICE) begin
      r = predict_slice();
    end else if (op == tfq_pkg::OP_KILL) begin
      r.id = id;
      r.oc = tfq_pkg::OC_KILL_MISS;
      for (int k = 0; k < lvl_q[1].size(); k++) begin
        if (lvl_q[1][k].id == id) begin
          lvl_q[1].delete(k);
          r.lvl = tfq_pkg::LVL_1;
          r.oc = tfq_pkg::OC_KILLED;
          break;
        end
      end
    end
    return r;
  endfunction

  // Send one item after a random gap; predict its result on acceptance.
  // Valid stays high after acceptance until the next gap or drain drops it.
  task automatic send_item(logic [1:0] op, logic [15:0] id, logic [15:0] len, logic io);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_proc_id <= id;
    in_job_length <= len;
    in_io_request <= io;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.insert(expected_results.size(), predict_item(op, id, len, io));
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result outcome", int'(out_outcome), -1);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_served_id !== want.id) report("served_id", out_served_id, want.id);
        if (out_ran_ticks !== want.ticks) report("ran_ticks", out_ran_ticks, want.ticks);
        if (out_level !== want.lvl) report("level", out_level, want.lvl);
        if (out_outcome !== want.oc) report("outcome", out_outcome, want.oc);
        if (out_boosted !== want.boost) report("boosted", out_boosted, want.boost);
      end
    end
  end

  // After each taken result, draw how long to stall; stall_max 0 disables.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n = $urandom_range(0, stall_max);
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // Drop valid, wait until every expectation is met, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      tfq_pkg::CFG_QUANTUM1: quantum[1] = val[7:0];
      tfq_pkg::CFG_QUANTUM2: quantum[2] = val[7:0];
      tfq_pkg::CFG_QUANTUM3: quantum[3] = val[7:0];
      tfq_pkg::CFG_LIMIT2:   limit2 = val;
      tfq_pkg::CFG_LIMIT3:   limit3 = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] q1, logic [7:0] q2, logic [7:0] q3,
                            logic [15:0] l2, logic [15:0] l3);
    drain();
    write_reg(tfq_pkg::CFG_QUANTUM1, {8'h00, q1});
    write_reg(tfq_pkg::CFG_QUANTUM2, {8'h00, q2});
    write_reg(tfq_pkg::CFG_QUANTUM3, {8'h00, q3});
    write_reg(tfq_pkg::CFG_LIMIT2, l2);
    write_reg(tfq_pkg::CFG_LIMIT3, l3);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] rand_id();
    return use_ids_small ? 16'($urandom_range(0, 31)) : 16'($urandom);
  endfunction

  // Directed: field extremes, every operation, zero length, kill hit and miss,
  // no-op.
  task automatic test_directed();
    send_item(tfq_pkg::OP_SLICE, 0, 0, 0);
    send_item(tfq_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 1);
    send_item(tfq_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 1);
    send_item(tfq_pkg::OP_ADD, 0, 0, 0);
    send_item(tfq_pkg::OP_ADD, 16'h5A5A, 16'd20, 0);
    send_item(tfq_pkg::OP_KILL, 16'h1234, 0, 0);
    send_item(tfq_pkg::OP_KILL, 16'h5A5A, 0, 0);
    send_item(tfq_pkg::OP_SLICE, 0, 0, 0);
    send_item(tfq_pkg::OP_SLICE, 0, 0, 0);
    send_item(tfq_pkg::OP_SLICE, 0, 0, 0);
    send_item(tfq_pkg::OP_KILL, 16'hFFFF, 0, 0);
    send_item(tfq_pkg::OP_SLICE, 0, 0, 0);
  endtask

  // Fill every level past capacity, then slice to exercise swaps and rejects.
  task automatic test_fill();
    for (int i = 0; i < 3 * LEVEL_CAP + 2; i++)
      send_item(tfq_pkg::OP_ADD, 16'(i + 100), 16'($urandom_range(1, 300)),
                1'($urandom_range(0, 3) == 0));
    for (int i = 0; i < 60; i++) send_item(tfq_pkg::OP_SLICE, 0, 0, 0);
  endtask

  // Mostly well-formed add/slice traffic with random content, some kills and no-ops.
  task automatic test_random(int n);
    int pick;
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: len = 16'($urandom);
        1: len = 0;
        default: len = 16'($urandom_range(1, 80));
      endcase
      if (pick < 40) send_item(tfq_pkg::OP_ADD, rand_id(), len, 1'($urandom_range(0, 1)));
      else if (pick < 85)
        send_item(tfq_pkg::OP_SLICE, rand_id(), len, 1'($urandom_range(0, 1)));
      else if (pick < 96) begin
        if (lvl_q[1].size() > 0 && $urandom_range(0, 1))
          send_item(tfq_pkg::OP_KILL, lvl_q[1][$urandom_range(0, lvl_q[1].size() - 1)].id,
                    len, 0);
        else
          send_item(tfq_pkg::OP_KILL, rand_id(), len, 0);
      end else send_item(tfq_pkg::OP_NOP, rand_id(), len, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_fill();
    stall_max = 5;
    test_random(300);
    // Extremes: smallest quanta with no boosting, largest quanta with eager boosting.
    set_config(8'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    test_random(250);
    set_config(8'd255, 8'd255, 8'd255, 16'd0, 16'd0);
    use_ids_small = 0;
    test_random(250);
    use_ids_small = 1;
    set_config(8'd3, 8'd7, 8'd200, 16'd10, 16'd500);
    stall_max = 0;
    test_random(300);
    stall_max = 5;
    set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom_range(0, 100)));
    test_random(300);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/tfq_pkg.sv
rtl/tfq_ram.sv
rtl/tfq_datapath.sv
rtl/tfq_ctrl.sv
rtl/three_level_feedback_queue_scheduler.sv
rtl/tfq_checker.sv
sim/tb.sv
